### rtl/peri_event_bin_accumulator_top_defines.svh
// Assertion macros for the checker file of this block.
`ifndef PERI_EVENT_BIN_ACCUMULATOR_TOP_DEFINES_SVH
`define PERI_EVENT_BIN_ACCUMULATOR_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PEBA_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PEBA_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/peba_pkg.sv
package peba_pkg;

  localparam int MAX_TRIALS  = 64;
  localparam int MAX_NEURONS = 16;
  localparam int MAX_WIDTH   = 64;

  localparam int TRIAL_AW  = $clog2(MAX_TRIALS);
  localparam int NEURON_AW = $clog2(MAX_NEURONS);
  localparam int OFFSET_AW = $clog2(MAX_WIDTH);
  localparam int BIN_AW    = TRIAL_AW + NEURON_AW + OFFSET_AW;
  localparam int BIN_COUNT = MAX_TRIALS * MAX_NEURONS * MAX_WIDTH;

  localparam int CMD_W   = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int TIME_W  = 32;
  localparam int INTEN_W = 16;
  localparam int SUM_W   = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPIKE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIALS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 7'd64;

  typedef struct packed {
    logic                latch;
    logic                trial_wr;
    logic                trial_rd;
    logic [TRIAL_AW-1:0] trial_idx;
    logic                clr_wr;
    logic [BIN_AW-1:0]   clr_addr;
    logic                rd_issue;
    logic                rd_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] trial_lim;
  } dp_stat_t;

endpackage

### rtl/peba_ram.sv
module peba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/peba_ctrl.sv
module peba_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [peba_pkg::CMD_W-1:0] cmd,
  input  peba_pkg::dp_stat_t         stat,
  output logic                       busy,
  output peba_pkg::ctrl_cmd_t        ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_SPIKE    = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_READ_OUT = 3'd4;

  localparam logic [peba_pkg::BIN_AW-1:0] CLR_LAST =
    peba_pkg::BIN_AW'(peba_pkg::BIN_COUNT - 1);

  logic [2:0]                  state, state_next;
  logic [peba_pkg::BIN_AW-1:0] cnt, cnt_next;
  logic [peba_pkg::BIN_AW-1:0] lim_ext;
  logic                        accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign lim_ext = {{(peba_pkg::BIN_AW - peba_pkg::CFG_W){1'b0}}, stat.trial_lim};

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ctl           = '0;
    ctl.latch     = accept;
    ctl.trial_idx = cnt[peba_pkg::TRIAL_AW-1:0];
    ctl.clr_addr  = cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            peba_pkg::CMD_LOAD: begin
              ctl.trial_wr = 1'b1;
            end
            peba_pkg::CMD_SPIKE: begin
              state_next = S_SPIKE;
              cnt_next   = '0;
            end
            peba_pkg::CMD_READ: begin
              state_next = S_READ;
            end
            peba_pkg::CMD_CLEAR: begin
              state_next = S_CLEAR;
              cnt_next   = '0;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SPIKE: begin
        // issue one trial per cycle, then drain two pipeline stages
        ctl.trial_rd = (cnt < lim_ext);
        if (cnt == lim_ext + peba_pkg::BIN_AW'(1)) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_READ: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_READ_OUT;
      end
      S_READ_OUT: begin
        ctl.rd_load = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### rtl/peba_dp.sv
module peba_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  peba_pkg::ctrl_cmd_t                 ctl,
  output peba_pkg::dp_stat_t                  stat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [peba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [peba_pkg::CFG_W-1:0]          cfg_data,
  input  logic [peba_pkg::TRIAL_AW-1:0]       trial_index,
  input  logic [peba_pkg::NEURON_AW-1:0]      neuron_index,
  input  logic [peba_pkg::TIME_W-1:0]         event_time,
  input  logic signed [peba_pkg::INTEN_W-1:0] intensity,
  input  logic [peba_pkg::OFFSET_AW-1:0]      bin_offset,
  output logic                                result_valid,
  output logic signed [peba_pkg::SUM_W-1:0]   bin_sum
);

  localparam int SUM_W = peba_pkg::SUM_W;

  logic [peba_pkg::CFG_W-1:0]     window_width, trial_count;
  logic [peba_pkg::CFG_W-1:0]     w_eff;
  logic [peba_pkg::NEURON_AW-1:0] item_neuron;
  logic [peba_pkg::TIME_W-1:0]    item_time;
  logic [peba_pkg::INTEN_W-1:0]   item_inten;
  logic [peba_pkg::BIN_AW-1:0]    item_addr;

  logic                          s1_valid;
  logic [peba_pkg::TRIAL_AW-1:0] s1_trial;
  logic [peba_pkg::TIME_W-1:0]   start_time;
  logic [peba_pkg::TIME_W-1:0]   diff;
  logic                          match;
  logic [peba_pkg::BIN_AW-1:0]   spike_addr;

  logic                        s2_valid;
  logic [peba_pkg::BIN_AW-1:0] s2_addr;
  logic [SUM_W-1:0]            bin_rdata;
  logic [SUM_W:0]              sum_wide;
  logic [SUM_W-1:0]            sum_sat;

  logic                        bin_we, bin_re;
  logic [peba_pkg::BIN_AW-1:0] bin_waddr, bin_raddr;
  logic [SUM_W-1:0]            bin_wdata;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= peba_pkg::CFG_RESET_VAL;
      trial_count  <= peba_pkg::CFG_RESET_VAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        peba_pkg::CFG_WINDOW: window_width <= cfg_data;
        peba_pkg::CFG_TRIALS: trial_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (window_width > peba_pkg::CFG_W'(peba_pkg::MAX_WIDTH)) ?
                 peba_pkg::CFG_W'(peba_pkg::MAX_WIDTH) : window_width;
  assign stat.trial_lim = (trial_count > peba_pkg::CFG_W'(peba_pkg::MAX_TRIALS)) ?
                          peba_pkg::CFG_W'(peba_pkg::MAX_TRIALS) : trial_count;

  // Hold the accepted item for the duration of its work.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_neuron <= neuron_index;
      item_time   <= event_time;
      item_inten  <= intensity;
      item_addr   <= {trial_index, neuron_index, bin_offset};
    end
  end

  peba_ram #(
    .WIDTH(peba_pkg::TIME_W),
    .DEPTH(peba_pkg::MAX_TRIALS)
  ) u_trial_ram (
    .clk  (clk),
    .we   (ctl.trial_wr),
    .waddr(trial_index),
    .wdata(event_time),
    .re   (ctl.trial_rd),
    .raddr(ctl.trial_idx),
    .rdata(start_time)
  );

  // Stage 1: window test against the trial start.
  assign diff       = item_time - start_time;
  assign match      = (item_time >= start_time) &&
                      (diff < {{(peba_pkg::TIME_W - peba_pkg::CFG_W){1'b0}}, w_eff});
  assign spike_addr = {s1_trial, item_neuron, diff[peba_pkg::OFFSET_AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.trial_rd;
      s2_valid <= s1_valid && match;
    end
  end

  always_ff @(posedge clk) begin
    s1_trial <= ctl.trial_idx;
    s2_addr  <= spike_addr;
  end

  // Stage 2: saturating add and write back.
  assign sum_wide = {bin_rdata[SUM_W-1], bin_rdata} +
                    {{(SUM_W + 1 - peba_pkg::INTEN_W){item_inten[peba_pkg::INTEN_W-1]}},
                     item_inten};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign bin_we    = ctl.clr_wr || s2_valid;
  assign bin_waddr = ctl.clr_wr ? ctl.clr_addr : s2_addr;
  assign bin_wdata = ctl.clr_wr ? '0 : sum_sat;
  assign bin_re    = ctl.rd_issue || (s1_valid && match);
  assign bin_raddr = ctl.rd_issue ? item_addr : spike_addr;

  peba_ram #(
    .WIDTH(SUM_W),
    .DEPTH(peba_pkg::BIN_COUNT)
  ) u_bin_ram (
    .clk  (clk),
    .we   (bin_we),
    .waddr(bin_waddr),
    .wdata(bin_wdata),
    .re   (bin_re),
    .raddr(bin_raddr),
    .rdata(bin_rdata)
  );

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.rd_load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_load) begin
      bin_sum <= bin_rdata;
    end
  end

endmodule

### rtl/peri_event_bin_accumulator_top.sv
// Load: writes the trial start table and leaves busy low. Spike: busy while one trial start
//   is compared per cycle, then a two-stage read-add-write of the bin memory runs. Read: the
//   bin is read in S_READ, taken in S_READ_OUT, then registered. Transfers wait for busy low.
// Clear: cmd 3 and reset sweep all 65536 bins, one per cycle; busy stays high meanwhile.
// Reset: synchronous, active high; registers return to 64, bins are swept to zero.
// Results: bin_sum is valid for one cycle with result_valid; the receiver cannot stall.
module peri_event_bin_accumulator_top (
  input  logic                                clk,
  input  logic                                rst,
  // command channel: a transfer happens when start is high and busy is low
  input  logic                                start,
  output logic                                busy,
  input  logic [peba_pkg::CMD_W-1:0]          cmd,
  input  logic [peba_pkg::TRIAL_AW-1:0]       trial_index,
  input  logic [peba_pkg::NEURON_AW-1:0]      neuron_index,
  input  logic [peba_pkg::TIME_W-1:0]         event_time,
  input  logic signed [peba_pkg::INTEN_W-1:0] intensity,
  input  logic [peba_pkg::OFFSET_AW-1:0]      bin_offset,
  // result strobe
  output logic                                result_valid,
  output logic signed [peba_pkg::SUM_W-1:0]   bin_sum,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [peba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [peba_pkg::CFG_W-1:0]          cfg_data
);

  // Command bundle from the sequencer and status back from the datapath.
  peba_pkg::ctrl_cmd_t ctl;
  peba_pkg::dp_stat_t  stat;

  // Sequencer: decodes commands, walks trial entries during a spike,
  // and sweeps the bin memory after reset and on a clear command.
  peba_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .stat (stat),
    .busy (busy),
    .ctl  (ctl)
  );

  // Datapath: configuration registers, trial start table, window test,
  // saturating bin accumulation and the result register.
  peba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .trial_index (trial_index),
    .neuron_index(neuron_index),
    .event_time  (event_time),
    .intensity   (intensity),
    .bin_offset  (bin_offset),
    .result_valid(result_valid),
    .bin_sum     (bin_sum)
  );

endmodule

### rtl/peba_checker.sv
`include "peri_event_bin_accumulator_top_defines.svh"

module peba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [peba_pkg::CMD_W-1:0] cmd,
  input logic                       result_valid
);

  // Reset always starts the clearing sweep.
  `PEBA_CHECK_ALWAYS(a_reset_busy, clk, rst |=> busy, "not busy after reset")

  // A result is a single-cycle strobe.
  `PEBA_CHECK(a_result_pulse, clk, rst, result_valid |=> !result_valid, "result strobe too long")

  // Every result traces back to an accepted read transfer.
  `PEBA_CHECK(a_result_src, clk, rst, result_valid |-> $past(start && !busy && cmd == peba_pkg::CMD_READ, 3), "result without read")

  // A read transfer blocks the command channel while it runs.
  `PEBA_CHECK(a_read_busy, clk, rst, (start && !busy && cmd == peba_pkg::CMD_READ) |=> busy, "read not busy")

endmodule

bind peri_event_bin_accumulator_top peba_checker u_peba_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cmd         (cmd),
  .result_valid(result_valid)
);
